// ===== rtl/ohm_pkg.sv =====
// Package with the types, codes and helper functions of the hash map.
`timescale 1ns / 1ps
package ohm_pkg;

  localparam int unsigned Capacity = 256;
  localparam int unsigned IdxW = $clog2(Capacity);
  localparam int unsigned CntW = IdxW + 1;

  // Slot marks.
  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_USED  = 2'd1;
  localparam logic [1:0] MARK_TOMB  = 2'd2;

  // Request codes.
  localparam logic [1:0] FUNC_SET  = 2'd0;
  localparam logic [1:0] FUNC_GET  = 2'd1;
  localparam logic [1:0] FUNC_DEL  = 2'd2;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  // Key kinds with special handling.
  localparam logic [3:0] KIND_NIL   = 4'd0;
  localparam logic [3:0] KIND_INT   = 4'd2;
  localparam logic [3:0] KIND_FLOAT = 4'd3;
  localparam logic [3:0] KIND_STR   = 4'd4;

  // Result codes.
  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_UPDATED  = 3'd1;
  localparam logic [2:0] ST_FOUND    = 3'd2;
  localparam logic [2:0] ST_MISSING  = 3'd3;
  localparam logic [2:0] ST_DELETED  = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;
  localparam logic [2:0] ST_NILKEY   = 3'd6;

  // Entry width of the slot data memory: key kind, key, hash, value kind, value.
  localparam int unsigned EntryW = 4 + 64 + 32 + 4 + 64;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  key_kind;
    logic [63:0] key_word;
    logic [31:0] key_hash;
    logic [3:0]  value_kind;
    logic [63:0] value_word;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  found_kind;
    logic [63:0] found_word;
  } rsp_t;

  typedef struct packed {
    logic [3:0]  key_kind;
    logic [63:0] key_word;
    logic [31:0] key_hash;
    logic [3:0]  value_kind;
    logic [63:0] value_word;
  } entry_t;

  function automatic logic [31:0] hash_of(logic [3:0] kind, logic [63:0] word,
                                         logic [31:0] hin);
    logic [31:0] h;
    if (kind == KIND_STR) begin
      h = hin;
    end else if (kind == KIND_INT) begin
      h = word[31:0] ^ word[63:32];
    end else begin
      h = word[31:0];
    end
    return h;
  endfunction

  function automatic logic is_nan(logic [63:0] w);
    return (w[62:52] == 11'h7FF) && (w[51:0] != 52'd0);
  endfunction

  function automatic logic keys_equal(logic [3:0] kind, logic [63:0] a, logic [63:0] b);
    logic eq;
    eq = (a == b);
    if (kind == KIND_FLOAT) begin
      if (is_nan(a) || is_nan(b)) begin
        eq = 1'b0;
      end else if (((a | b) & 64'h7FFF_FFFF_FFFF_FFFF) == 64'd0) begin
        eq = 1'b1;
      end
    end
    return eq;
  endfunction

endpackage

// ===== rtl/open_addressing_hash_map.sv =====
// Top level of the open-addressing hash map with linear probing.
// Each probed slot takes a read state and a check state, and a finishing state follows;
// then the result is presented; a nil key or FUNC_NONE request skips the probe.
// Throughput: one transaction at a time; the next is accepted in the cycle after the
// result is taken.
// Reset: asynchronous, active low; a clearing pass then empties every slot,
// during which no transaction is accepted.
`timescale 1ns / 1ps
module open_addressing_hash_map
  import ohm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  req_t       in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output rsp_t       out_data_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  ohm_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid  (in_valid_i),
    .in_stall  (in_stall_o),
    .in_data   (in_data_i),
    .out_valid (out_valid_o),
    .out_stall (out_stall_i),
    .out_data  (out_data_o),
    .cfg_we    (cfg_we_i),
    .cfg_wdata (cfg_wdata_i)
  );

endmodule

// ===== rtl/ohm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module ohm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/ohm_ctrl.sv =====
// Probe sequencer: reads and checks the slots in turn and finishes the request.
`timescale 1ns / 1ps
module ohm_ctrl
  import ohm_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid,
  output logic            in_stall,
  input  req_t            in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output rsp_t            out_data,
  input  logic            cfg_we,
  input  logic [7:0]      cfg_wdata
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]      state_q, state_d;
  req_t            req_q;
  logic [31:0]     hash_q;
  logic [31:0]     in_hash;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [CntW-1:0] n_q, n_d;
  logic            tomb_ok_q, tomb_ok_d;
  logic [IdxW-1:0] tomb_idx_q, tomb_idx_d;
  logic            hit_q, hit_d, empty_ok_q, empty_ok_d;
  logic [CntW-1:0] used_q, used_d;
  logic [7:0]      limit_q;
  rsp_t            rsp_q, rsp_d;

  logic            mark_we, data_we;
  logic [IdxW-1:0] mark_waddr, data_waddr;
  logic [1:0]      mark_wdata, mark_rdata;
  entry_t          data_wdata, data_rdata;
  logic [IdxW-1:0] raddr;

  ohm_ram #(.Width(2), .Depth(Capacity)) u_mark (
    .clk_i, .we_i(mark_we), .waddr_i(mark_waddr), .wdata_i(mark_wdata),
    .raddr_i(raddr), .rdata_o(mark_rdata)
  );

  ohm_ram #(.Width(EntryW), .Depth(Capacity)) u_data (
    .clk_i, .we_i(data_we), .waddr_i(data_waddr), .wdata_i(data_wdata),
    .raddr_i(raddr), .rdata_o(data_rdata)
  );

  assign raddr     = idx_q;
  assign in_stall  = (state_q != S_IDLE);
  assign out_valid = (state_q == S_OUT);
  assign out_data  = rsp_q;
  assign in_hash   = hash_of(in_data.key_kind, in_data.key_word, in_data.key_hash);

  logic match;
  assign match = (mark_rdata == MARK_USED) && (data_rdata.key_hash == hash_q) &&
                 (data_rdata.key_kind == req_q.key_kind) &&
                 keys_equal(req_q.key_kind, data_rdata.key_word, req_q.key_word);

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    n_d        = n_q;
    tomb_ok_d  = tomb_ok_q;
    tomb_idx_d = tomb_idx_q;
    hit_d      = hit_q;
    empty_ok_d = empty_ok_q;
    used_d     = used_q;
    rsp_d      = rsp_q;
    mark_we    = 1'b0;
    mark_waddr = idx_q;
    mark_wdata = MARK_EMPTY;
    data_we    = 1'b0;
    data_waddr = idx_q;
    data_wdata = '0;
    case (state_q)
      S_CLEAR: begin
        // Sweep every slot to empty after reset.
        mark_we = 1'b1;
        idx_d   = idx_q + 1'b1;
        if (idx_q == IdxW'(Capacity - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          idx_d      = in_hash[IdxW-1:0];
          n_d        = '0;
          tomb_ok_d  = 1'b0;
          hit_d      = 1'b0;
          empty_ok_d = 1'b0;
          rsp_d      = '0;
          if (in_data.key_kind == KIND_NIL) begin
            rsp_d.status = ST_NILKEY;
            state_d      = S_OUT;
          end else if (in_data.func == FUNC_NONE) begin
            rsp_d.status = ST_MISSING;
            state_d      = S_OUT;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (mark_rdata == MARK_EMPTY) begin
          empty_ok_d = 1'b1;
          state_d    = S_DONE;
        end else if (match) begin
          hit_d   = 1'b1;
          state_d = S_DONE;
        end else begin
          if ((mark_rdata == MARK_TOMB) && !tomb_ok_q) begin
            tomb_ok_d  = 1'b1;
            tomb_idx_d = idx_q;
          end
          n_d = n_q + 1'b1;
          if (n_q == CntW'(Capacity - 1)) begin
            state_d = S_DONE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_READ;
          end
        end
      end
      S_DONE: begin
        state_d = S_OUT;
        case (req_q.func)
          FUNC_SET: begin
            if (hit_q) begin
              data_we    = 1'b1;
              data_wdata = {data_rdata.key_kind, data_rdata.key_word,
                            data_rdata.key_hash, req_q.value_kind, req_q.value_word};
              rsp_d.status = ST_UPDATED;
            end else if ((used_q >= {1'b0, limit_q}) || (!tomb_ok_q && !empty_ok_q)) begin
              rsp_d.status = ST_FULL;
            end else begin
              mark_we    = 1'b1;
              mark_wdata = MARK_USED;
              mark_waddr = tomb_ok_q ? tomb_idx_q : idx_q;
              data_we    = 1'b1;
              data_waddr = mark_waddr;
              data_wdata = {req_q.key_kind, req_q.key_word, hash_q,
                            req_q.value_kind, req_q.value_word};
              used_d       = used_q + 1'b1;
              rsp_d.status = ST_INSERTED;
            end
          end
          FUNC_GET: begin
            if (hit_q) begin
              rsp_d.status     = ST_FOUND;
              rsp_d.found_kind = data_rdata.value_kind;
              rsp_d.found_word = data_rdata.value_word;
            end else begin
              rsp_d.status = ST_MISSING;
            end
          end
          default: begin
            if (hit_q) begin
              mark_we      = 1'b1;
              mark_wdata   = MARK_TOMB;
              rsp_d.status = ST_DELETED;
            end else begin
              rsp_d.status = ST_MISSING;
            end
          end
        endcase
      end
      S_OUT: begin
        if (!out_stall) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      idx_q      <= '0;
      n_q        <= '0;
      tomb_ok_q  <= 1'b0;
      hit_q      <= 1'b0;
      empty_ok_q <= 1'b0;
      used_q     <= '0;
      limit_q    <= 8'd192;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      n_q        <= n_d;
      tomb_ok_q  <= tomb_ok_d;
      hit_q      <= hit_d;
      empty_ok_q <= empty_ok_d;
      used_q     <= used_d;
      if (cfg_we) begin
        limit_q <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tomb_idx_q <= tomb_idx_d;
    rsp_q      <= rsp_d;
    if ((state_q == S_IDLE) && in_valid) begin
      req_q  <= in_data;
      hash_q <= in_hash;
    end
  end

endmodule
